[rtl/core/assert_macros.svh]
// Assertion macros used by the oscillator bank top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mnco_pkg.sv]
// Types, constants and table functions of the oscillator bank.
package mnco_pkg;

    localparam int NCH_DEF    = 16;
    localparam int LUT_AW_DEF = 10;

    localparam int CMD_W      = 3;
    localparam int CH_W       = 4;
    localparam int WORD_W     = 32;
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 20;
    localparam int ROM_W      = 32;
    localparam int ENTRY_W    = 2 * WORD_W + SAMPLE_W;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 120;
    localparam int DRAIN_LEN  = 5;

    localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;
    localparam int unsigned SIN_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};
    localparam int unsigned COS_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_STEP  = 3'd0,
        CMD_WR_PHASE = 3'd1,
        CMD_WR_AMPL  = 3'd2,
        CMD_TX       = 3'd3,
        CMD_RX       = 3'd4,
        CMD_MOD      = 3'd5,
        CMD_READ     = 3'd6,
        CMD_NOP      = 3'd7
    } t_cmd;

    typedef struct packed {
        logic                       vld;
        logic [1:0]                 quad;
        logic signed [SAMPLE_W-1:0] ampl;
    } t_tone_ctl;

    typedef struct packed {
        logic                       vld;
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } t_tone_res;

    // Round half up from Q2.30 to Q1.15 and saturate.
    function automatic logic signed [SAMPLE_W-1:0] round_sat_q15(input logic signed [33:0] p);
        logic signed [33:0]         r;
        logic signed [SAMPLE_W-1:0] res;
        r = (p + 34'sd16384) >>> 15;
        if (r > 34'sd32767) begin
            res = 16'sh7fff;
        end else if (r < -34'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = r[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [15:0] q30_to_q15(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v < 64'sd0) ? 64'sd0 : v;
        t = (t + 64'sd16384) >>> 15;
        return (t > 64'sd32767) ? 16'd32767 : t[15:0];
    endfunction

    // One quarter-wave entry: cosine in the high half, sine in the low half.
    function automatic logic [ROM_W-1:0] qw_entry(input int unsigned idx,
                                                  input int unsigned tbits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        st;
        logic [63:0]        ct;
        logic signed [63:0] ss;
        logic signed [63:0] cs;
        x  = (PIHALF_Q30 * 64'(idx) + ((64'd1 << tbits) >> 1)) >> tbits;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        st = x;
        ss = $signed(x);
        ct = 64'd1 << 30;
        cs = $signed(ct);
        for (int k = 0; k < 7; k++) begin
            st = ((st * x2) >> 30) / SIN_DIV[k];
            ct = ((ct * x2) >> 30) / COS_DIV[k];
            if ((k % 2) == 0) begin
                ss = ss - $signed(st);
                cs = cs - $signed(ct);
            end else begin
                ss = ss + $signed(st);
                cs = cs + $signed(ct);
            end
        end
        return {q30_to_q15(cs), q30_to_q15(ss)};
    endfunction

endpackage

[rtl/core/multichannel_nco_bank_core.sv]
// Top level of the multichannel oscillator bank with per-channel state in RAM.
//
// Requests arrive on the slave stream: tuser carries the command, tlast the
// buffer mark, and tdata the channel, new word, amplitude and complex sample.
// Every request yields exactly one result on the master stream, carrying the
// tone, sum or modulated sample together with the addressed channel's step,
// phase and amplitude after the request; tlast is copied through.
// Phase, step and amplitude of all channels sit in one RAM entry per channel.
// A request is accepted in the idle state, then one channel entry is read per
// cycle: all channels for a tx sum, a single entry for any other command.
// The drain state then lets the tone pipeline empty, and the finish state
// loads the output register. The single read port of the channel RAM is why
// a tx sum reads its channels one after another.
// Reset clears per-entry valid bits, so every channel reads as zero without a
// clearing pass; the cosine table is constant and needs no load.
// A result waiting in the output register does not block the next request;
// only a second finished result waits until the receiver takes the first.
`include "assert_macros.svh"

module multichannel_nco_bank_core
    import mnco_pkg::*;
#(
    parameter int NCH    = NCH_DEF,
    parameter int LUT_AW = LUT_AW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // channel, word_value, amplitude, sample_i, sample_q (from bit 0 up), zero padded
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // command
    input  logic [CMD_W-1:0]      i_s_axis_tuser,
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // out_i, out_q, step_now, phase_now, ampl_now (from bit 0 up)
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tlast
);

    localparam int AW     = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int CNT_W  = ($clog2(NCH + 1) > $clog2(DRAIN_LEN + 1)) ?
                            $clog2(NCH + 1) : $clog2(DRAIN_LEN + 1);
    localparam int ACC_W  = OUT_W + $clog2(NCH + 1);
    localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(-(1 << (OUT_W - 1)));

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    logic [CNT_W-1:0]           r_cnt;
    logic [CNT_W-1:0]           n_cnt;

    // Request registers.
    t_cmd                       r_cmd;
    logic [CH_W-1:0]            r_channel;
    logic [WORD_W-1:0]          r_word;
    logic signed [SAMPLE_W-1:0] r_amp;
    logic signed [SAMPLE_W-1:0] r_si;
    logic signed [SAMPLE_W-1:0] r_sq;
    logic                       r_last;
    logic                       r_ok;

    logic                       w_accept;
    logic                       w_issue;
    logic                       w_last_issue;
    logic                       w_load_out;
    logic                       w_is_tx;
    logic [AW-1:0]              w_rd_addr;
    logic [AW-1:0]              w_ch_addr;

    logic [NCH-1:0]             r_valid;
    logic                       r_p1;
    logic [AW-1:0]              r_p1_addr;
    logic                       r_p1_live;

    logic [ENTRY_W-1:0]         ram_rdata;
    logic [ENTRY_W-1:0]         w_ent;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ENTRY_W-1:0]         ram_wdata;
    logic [WORD_W-1:0]          w_phase;
    logic [WORD_W-1:0]          w_step;
    logic [SAMPLE_W-1:0]        w_ampl;
    logic [WORD_W-1:0]          w_new_phase;
    logic [WORD_W-1:0]          w_new_step;
    logic [SAMPLE_W-1:0]        w_new_ampl;
    logic                       w_wr_ok;
    logic                       w_tone_cmd;

    logic [ROM_W-1:0]           rom_data;
    t_tone_ctl                  r_t2;
    t_tone_res                  w_tone;
    t_tone_res                  w_mod;

    logic signed [ACC_W-1:0]    r_acc_i;
    logic signed [ACC_W-1:0]    r_acc_q;
    logic [ENTRY_W-1:0]         r_now;
    logic signed [OUT_W-1:0]    w_out_i;
    logic signed [OUT_W-1:0]    w_out_q;

    logic                       r_out_vld;
    logic [OUT_DATA_W-1:0]      r_out_data;
    logic                       r_out_last;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = o_s_axis_tready && i_s_axis_tvalid;
    assign w_is_tx         = (r_cmd == CMD_TX);
    assign w_tone_cmd      = (r_cmd == CMD_TX) || (r_cmd == CMD_RX) || (r_cmd == CMD_MOD);
    assign w_ch_addr       = AW'(r_channel);
    assign w_rd_addr       = w_is_tx ? r_cnt[AW-1:0] : (r_ok ? w_ch_addr : '0);
    assign w_last_issue    = w_is_tx ? (r_cnt == CNT_W'(NCH - 1)) : 1'b1;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        w_issue    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = ST_RUN;
                    n_cnt   = '0;
                end
            end
            ST_RUN: begin
                w_issue = 1'b1;
                if (w_last_issue) begin
                    n_state = ST_DRAIN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (r_cnt == CNT_W'(DRAIN_LEN - 1)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FINISH: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Entries never written since reset read as zero.
    assign w_ent   = r_p1_live ? ram_rdata : '0;
    assign w_phase = w_ent[WORD_W-1:0];
    assign w_step  = w_ent[2*WORD_W-1:WORD_W];
    assign w_ampl  = w_ent[ENTRY_W-1:2*WORD_W];

    always_comb begin
        w_new_phase = w_phase;
        w_new_step  = w_step;
        w_new_ampl  = w_ampl;
        w_wr_ok     = 1'b0;
        case (r_cmd)
            CMD_WR_STEP: begin
                w_new_step = r_word;
                w_wr_ok    = r_ok;
            end
            CMD_WR_PHASE: begin
                w_new_phase = r_word;
                w_wr_ok     = r_ok;
            end
            CMD_WR_AMPL: begin
                w_new_ampl = r_amp;
                w_wr_ok    = r_ok;
            end
            CMD_TX: begin
                w_new_phase = w_phase + w_step;
                w_wr_ok     = 1'b1;
            end
            CMD_RX, CMD_MOD: begin
                w_new_phase = w_phase + w_step;
                w_wr_ok     = r_ok;
            end
            default: begin
                w_wr_ok = 1'b0;
            end
        endcase
    end

    assign ram_we    = r_p1 && w_wr_ok;
    assign ram_waddr = r_p1_addr;
    assign ram_wdata = {w_new_ampl, w_new_step, w_new_phase};

    mnco_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NCH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (ram_rdata)
    );

    mnco_rom #(
        .LUT_AW (LUT_AW)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_phase[29 -: LUT_AW]),
        .o_data (rom_data)
    );

    mnco_tone u_tone (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_t2),
        .i_rom_data (rom_data),
        .i_sample_i (r_si),
        .i_sample_q (r_sq),
        .o_tone     (w_tone),
        .o_mod      (w_mod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_p1      <= 1'b0;
            r_valid   <= '0;
            r_t2      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_p1     <= w_issue;
            r_t2.vld <= r_p1 && w_tone_cmd;
            if (r_p1) begin
                r_t2.quad <= w_phase[WORD_W-1:WORD_W-2];
                r_t2.ampl <= $signed(w_ampl);
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= t_cmd'(i_s_axis_tuser);
            r_channel <= i_s_axis_tdata[CH_W-1:0];
            r_word    <= i_s_axis_tdata[35:4];
            r_amp     <= $signed(i_s_axis_tdata[51:36]);
            r_si      <= $signed(i_s_axis_tdata[67:52]);
            r_sq      <= $signed(i_s_axis_tdata[83:68]);
            r_last    <= i_s_axis_tlast;
            r_ok      <= (int'(i_s_axis_tdata[CH_W-1:0]) < NCH);
            r_acc_i   <= '0;
            r_acc_q   <= '0;
            r_now     <= '0;
        end else begin
            if (w_tone.vld) begin
                r_acc_i <= r_acc_i + ACC_W'(w_tone.re);
                r_acc_q <= r_acc_q + ACC_W'(w_tone.im);
            end
            if (r_p1 && r_ok && (r_p1_addr == w_ch_addr)) begin
                r_now <= ram_wdata;
            end
        end
        if (w_issue) begin
            r_p1_addr <= w_rd_addr;
            r_p1_live <= r_valid[w_rd_addr];
        end
        // The entry holds amplitude, step and phase; the result wants step below phase.
        if (w_load_out) begin
            r_out_data <= {r_now[ENTRY_W-1:2*WORD_W], r_now[WORD_W-1:0],
                           r_now[2*WORD_W-1:WORD_W], w_out_q, w_out_i};
            r_out_last <= r_last;
        end
    end

    always_comb begin
        w_out_i = '0;
        w_out_q = '0;
        case (r_cmd)
            CMD_TX: begin
                if (r_acc_i > ACC_HI) begin
                    w_out_i = ACC_HI[OUT_W-1:0];
                end else if (r_acc_i < ACC_LO) begin
                    w_out_i = ACC_LO[OUT_W-1:0];
                end else begin
                    w_out_i = r_acc_i[OUT_W-1:0];
                end
                if (r_acc_q > ACC_HI) begin
                    w_out_q = ACC_HI[OUT_W-1:0];
                end else if (r_acc_q < ACC_LO) begin
                    w_out_q = ACC_LO[OUT_W-1:0];
                end else begin
                    w_out_q = r_acc_q[OUT_W-1:0];
                end
            end
            CMD_RX: begin
                if (r_ok) begin
                    w_out_i = {{(OUT_W - SAMPLE_W){w_tone.re[SAMPLE_W-1]}}, w_tone.re};
                    w_out_q = {{(OUT_W - SAMPLE_W){w_tone.im[SAMPLE_W-1]}}, w_tone.im};
                end
            end
            CMD_MOD: begin
                if (r_ok) begin
                    w_out_i = {{(OUT_W - SAMPLE_W){w_mod.re[SAMPLE_W-1]}}, w_mod.re};
                    w_out_q = {{(OUT_W - SAMPLE_W){w_mod.im[SAMPLE_W-1]}}, w_mod.im};
                end
            end
            default: begin
                w_out_i = '0;
                w_out_q = '0;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // Channel state is only written back while a request is being worked on.
    `ASSERT_SAME(a_no_write_idle, i_clk, i_rst_n, r_state == ST_IDLE, !ram_we,
        "channel RAM written while idle")

    // Every scaled tone must land before the result is selected.
    `ASSERT_SAME(a_tone_in_flight, i_clk, i_rst_n, w_tone.vld,
        (r_state == ST_RUN) || (r_state == ST_DRAIN),
        "scaled tone arrived outside the run or drain window")

    // A written entry is marked as holding data from then on.
    `ASSERT_NEXT(a_valid_set, i_clk, i_rst_n, ram_we, r_valid[$past(ram_waddr)],
        "written channel entry not marked valid")

endmodule

[rtl/core/mnco_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module mnco_ram
    import mnco_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = NCH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mnco_rom.sv]
// Quarter-wave cosine and sine table with a registered read port.
module mnco_rom
    import mnco_pkg::*;
#(
    parameter int LUT_AW = LUT_AW_DEF
) (
    input  logic              i_clk,
    input  logic [LUT_AW-1:0] i_addr,
    output logic [ROM_W-1:0]  o_data
);

    localparam int DEPTH = 1 << LUT_AW;

    logic [ROM_W-1:0] w_tbl [DEPTH];
    logic [ROM_W-1:0] r_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_tbl
        localparam logic [ROM_W-1:0] EntryVal = qw_entry(g, LUT_AW);
        assign w_tbl[g] = EntryVal;
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_tbl[i_addr];
    end

    assign o_data = r_data;

endmodule

[rtl/core/mnco_tone.sv]
// Quadrant rotation, amplitude scaling and complex modulation pipeline.
module mnco_tone
    import mnco_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_tone_ctl                  i_ctl,
    input  logic [ROM_W-1:0]           i_rom_data,
    input  logic signed [SAMPLE_W-1:0] i_sample_i,
    input  logic signed [SAMPLE_W-1:0] i_sample_q,
    output t_tone_res                  o_tone,
    output t_tone_res                  o_mod
);

    logic signed [SAMPLE_W-1:0] w_c;
    logic signed [SAMPLE_W-1:0] w_s;
    logic signed [SAMPLE_W-1:0] w_a;
    logic signed [SAMPLE_W-1:0] w_b;

    logic                       r_prod_vld;
    logic signed [31:0]         r_pa;
    logic signed [31:0]         r_pb;
    t_tone_res                  r_tone;
    logic                       r_mp_vld;
    logic signed [31:0]         r_p_ii;
    logic signed [31:0]         r_p_qq;
    logic signed [31:0]         r_p_iq;
    logic signed [31:0]         r_p_qi;
    t_tone_res                  r_mod;

    // Odd quadrants rotate by 90 degrees; the upper half-turn negates both parts.
    always_comb begin
        w_c = $signed(i_rom_data[ROM_W-1:SAMPLE_W]);
        w_s = $signed(i_rom_data[SAMPLE_W-1:0]);
        w_a = w_c;
        w_b = w_s;
        if (i_ctl.quad[0]) begin
            w_a = -w_s;
            w_b = w_c;
        end
        if (i_ctl.quad[1]) begin
            w_a = -w_a;
            w_b = -w_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_tone.vld <= 1'b0;
            r_mp_vld   <= 1'b0;
            r_mod.vld  <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.vld;
            r_tone.vld <= r_prod_vld;
            r_mp_vld   <= r_tone.vld;
            r_mod.vld  <= r_mp_vld;
        end
        if (i_ctl.vld) begin
            r_pa <= i_ctl.ampl * w_a;
            r_pb <= i_ctl.ampl * w_b;
        end
        if (r_prod_vld) begin
            r_tone.re <= round_sat_q15(34'(r_pa));
            r_tone.im <= round_sat_q15(34'(r_pb));
        end
        if (r_tone.vld) begin
            r_p_ii <= i_sample_i * r_tone.re;
            r_p_qq <= i_sample_q * r_tone.im;
            r_p_iq <= i_sample_i * r_tone.im;
            r_p_qi <= i_sample_q * r_tone.re;
        end
        if (r_mp_vld) begin
            r_mod.re <= round_sat_q15(34'(r_p_ii) - 34'(r_p_qq));
            r_mod.im <= round_sat_q15(34'(r_p_iq) + 34'(r_p_qi));
        end
    end

    assign o_tone = r_tone;
    assign o_mod  = r_mod;

endmodule

[verif/tb_multichannel_nco_bank_core.sv]
// Self-checking testbench for the multichannel oscillator bank, with its own predictor.
`timescale 1ns / 1ps

module tb_multichannel_nco_bank_core;

    typedef struct {
        mnco_pkg::t_cmd     cmd;
        logic [3:0]         ch;
        logic [31:0]        word;
        logic signed [15:0] amp;
        logic signed [15:0] si;
        logic signed [15:0] sq;
        logic               last;
    } nco_request_t;

    typedef struct {
        logic signed [19:0] oi;
        logic signed [19:0] oq;
        logic [31:0]        step;
        logic [31:0]        phase;
        logic signed [15:0] ampl;
        logic               last;
    } nco_result_t;

    typedef struct {
        nco_request_t req;
        bit           typed;
        nco_result_t  res;
    } stim_row_t;

    localparam int N_CHAN      = 16;
    localparam int TBL_ENTRIES = 1024;
    localparam int N_RANDOM    = 1450;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    logic [mnco_pkg::IN_DATA_W-1:0]    s_tdata = '0;
    logic [mnco_pkg::CMD_W-1:0]        s_tuser = '0;
    logic                              s_tlast = 1'b0;
    logic                              o_m_axis_tvalid;
    logic                              m_tready = 1'b0;
    logic [mnco_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata;
    logic                              o_m_axis_tlast;

    // Predictor state.
    logic [31:0]        nco_phase [N_CHAN];
    logic [31:0]        nco_step  [N_CHAN];
    logic signed [15:0] nco_ampl  [N_CHAN];
    logic [31:0]        cos_sin_rom [TBL_ENTRIES];

    nco_result_t pending_results [$];
    stim_row_t   directed_rows [$];
    int          error_count = 0;
    int          results_seen = 0;

    multichannel_nco_bank_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [15:0] clamp_to_q15(longint v);
        longint t;
        t = (v < 0) ? 0 : v;
        t = (t + 16384) >>> 15;
        return (t > 32767) ? 16'd32767 : t[15:0];
    endfunction

    // Power series for cos and sin over the first quarter turn, in Q30.
    function automatic void build_cos_sin_rom();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned st;
        longint unsigned ct;
        longint unsigned dv_s;
        longint unsigned dv_c;
        longint          ss;
        longint          cs;
        for (int i = 0; i < TBL_ENTRIES; i++) begin
            x  = (64'd1686629713 * 64'(i) + 64'd512) >> 10;
            x2 = (x * x + (64'd1 << 29)) >> 30;
            st = x;
            ss = longint'(x);
            ct = 64'd1 << 30;
            cs = longint'(ct);
            for (int k = 1; k <= 7; k++) begin
                dv_s = 64'((2 * k) * (2 * k + 1));
                dv_c = 64'((2 * k - 1) * (2 * k));
                st = ((st * x2) >> 30) / dv_s;
                ct = ((ct * x2) >> 30) / dv_c;
                if (k % 2 == 1) begin
                    ss = ss - longint'(st);
                    cs = cs - longint'(ct);
                end else begin
                    ss = ss + longint'(st);
                    cs = cs + longint'(ct);
                end
            end
            cos_sin_rom[i] = {clamp_to_q15(cs), clamp_to_q15(ss)};
        end
    endfunction

    function automatic logic signed [15:0] q15_round_sat(longint p);
        longint r;
        r = (p + 16384) >>> 15;
        if (r > 32767) begin
            return 16'sh7fff;
        end else if (r < -32768) begin
            return 16'sh8000;
        end
        return 16'(r);
    endfunction

    // Amplitude-scaled tone of one channel at its present phase.
    function automatic void channel_tone(int ch, output int re, output int im);
        logic [31:0] ph;
        logic [31:0] entry;
        int          a;
        int          b;
        int          tmp;
        ph    = nco_phase[ch];
        entry = cos_sin_rom[ph[29:20]];
        a     = int'(entry[31:16]);
        b     = int'(entry[15:0]);
        if (ph[30]) begin
            tmp = a;
            a   = -b;
            b   = tmp;
        end
        if (ph[31]) begin
            a = -a;
            b = -b;
        end
        re = int'(q15_round_sat(longint'(nco_ampl[ch]) * a));
        im = int'(q15_round_sat(longint'(nco_ampl[ch]) * b));
    endfunction

    function automatic nco_result_t apply_nco_request(nco_request_t r);
        nco_result_t res;
        int          re;
        int          im;
        longint      sum_i;
        longint      sum_q;
        res.oi = '0;
        res.oq = '0;
        case (r.cmd)
            mnco_pkg::CMD_WR_STEP:  nco_step[r.ch] = r.word;
            mnco_pkg::CMD_WR_PHASE: nco_phase[r.ch] = r.word;
            mnco_pkg::CMD_WR_AMPL:  nco_ampl[r.ch] = r.amp;
            mnco_pkg::CMD_TX: begin
                sum_i = 0;
                sum_q = 0;
                for (int j = 0; j < N_CHAN; j++) begin
                    channel_tone(j, re, im);
                    sum_i += re;
                    sum_q += im;
                end
                sum_i = (sum_i > 524287) ? 524287 : ((sum_i < -524288) ? -524288 : sum_i);
                sum_q = (sum_q > 524287) ? 524287 : ((sum_q < -524288) ? -524288 : sum_q);
                res.oi = 20'(sum_i);
                res.oq = 20'(sum_q);
                for (int j = 0; j < N_CHAN; j++) begin
                    nco_phase[j] = nco_phase[j] + nco_step[j];
                end
            end
            mnco_pkg::CMD_RX: begin
                channel_tone(r.ch, re, im);
                res.oi = 20'(re);
                res.oq = 20'(im);
                nco_phase[r.ch] = nco_phase[r.ch] + nco_step[r.ch];
            end
            mnco_pkg::CMD_MOD: begin
                channel_tone(r.ch, re, im);
                // Both products are summed exactly before the single rounding.
                res.oi = q15_round_sat(longint'(r.si) * re - longint'(r.sq) * im);
                res.oq = q15_round_sat(longint'(r.si) * im + longint'(r.sq) * re);
                nco_phase[r.ch] = nco_phase[r.ch] + nco_step[r.ch];
            end
            default: ;
        endcase
        res.step  = nco_step[r.ch];
        res.phase = nco_phase[r.ch];
        res.ampl  = nco_ampl[r.ch];
        res.last  = r.last;
        return res;
    endfunction

    function automatic void add_row(mnco_pkg::t_cmd c, int ch, logic [31:0] w, int amp,
                                    int si, int sq, bit last, bit typed,
                                    logic [31:0] e_step, logic [31:0] e_phase, int e_ampl);
        stim_row_t row;
        row.req.cmd   = c;
        row.req.ch    = 4'(ch);
        row.req.word  = w;
        row.req.amp   = 16'(amp);
        row.req.si    = 16'(si);
        row.req.sq    = 16'(sq);
        row.req.last  = last;
        row.typed     = typed;
        row.res.oi    = '0;
        row.res.oq    = '0;
        row.res.step  = e_step;
        row.res.phase = e_phase;
        row.res.ampl  = 16'(e_ampl);
        row.res.last  = last;
        directed_rows.push_back(row);
    endfunction

    // Offers one request from the current edge and returns at the edge that accepts it.
    task automatic drive_request(nco_request_t r, bit typed, nco_result_t typed_res);
        nco_result_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, r.sq, r.si, r.amp, r.word, r.ch};
        s_tuser  <= r.cmd;
        s_tlast  <= r.last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = apply_nco_request(r);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        logic [31:0] corners [6] = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                     32'hc000_0000, 32'h4000_0000};
        if ($urandom_range(0, 7) == 0) begin
            return corners[$urandom_range(0, 5)];
        end
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_q15();
        logic [15:0] corners [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        if ($urandom_range(0, 7) == 0) begin
            return corners[$urandom_range(0, 3)];
        end
        return 16'($urandom);
    endfunction

    // Stimulus.
    initial begin
        nco_request_t req;
        nco_result_t  dummy;
        int           pick;
        int           burst_left;
        int           gap;
        for (int c = 0; c < N_CHAN; c++) begin
            nco_phase[c] = '0;
            nco_step[c]  = '0;
            nco_ampl[c]  = '0;
        end
        build_cos_sin_rom();
        dummy = '{default: '0};

        add_row(mnco_pkg::CMD_READ, 0, 32'h0, 0, 0, 0, 1'b0, 1'b1, 32'h0, 32'h0, 0);
        add_row(mnco_pkg::CMD_READ, 15, 32'hffff_ffff, -1, -1, -1, 1'b1, 1'b1,
                32'h0, 32'h0, 0);
        add_row(mnco_pkg::CMD_WR_STEP, 0, 32'hffff_ffff, 0, 0, 0, 1'b0, 1'b1,
                32'hffff_ffff, 32'h0, 0);
        add_row(mnco_pkg::CMD_WR_PHASE, 0, 32'h0, 0, 0, 0, 1'b1, 1'b1,
                32'hffff_ffff, 32'h0, 0);
        add_row(mnco_pkg::CMD_WR_AMPL, 0, 32'h0, -32768, 0, 0, 1'b0, 1'b1,
                32'hffff_ffff, 32'h0, -32768);
        add_row(mnco_pkg::CMD_WR_AMPL, 15, 32'h0, 32767, 0, 0, 1'b0, 1'b1,
                32'h0, 32'h0, 32767);
        add_row(mnco_pkg::CMD_WR_PHASE, 15, 32'hc000_0000, 0, 0, 0, 1'b0, 1'b1,
                32'h0, 32'hc000_0000, 32767);
        add_row(mnco_pkg::CMD_WR_STEP, 15, 32'h4000_0000, 0, 0, 0, 1'b0, 1'b1,
                32'h4000_0000, 32'hc000_0000, 32767);
        add_row(mnco_pkg::CMD_RX, 0, 32'h0, 0, 0, 0, 1'b0, 1'b0, 0, 0, 0);
        add_row(mnco_pkg::CMD_RX, 15, 32'h0, 0, 0, 0, 1'b0, 1'b0, 0, 0, 0);
        add_row(mnco_pkg::CMD_MOD, 15, 32'h0, 0, -32768, -32768, 1'b0, 1'b0, 0, 0, 0);
        add_row(mnco_pkg::CMD_MOD, 0, 32'h0, 0, 32767, -32768, 1'b1, 1'b0, 0, 0, 0);
        add_row(mnco_pkg::CMD_TX, 3, 32'h0, 0, 0, 0, 1'b0, 1'b0, 0, 0, 0);
        // The unused command must leave every channel untouched.
        add_row(mnco_pkg::CMD_NOP, 5, 32'hffff_ffff, -1, -1, -1, 1'b1, 1'b1,
                32'h0, 32'h0, 0);
        add_row(mnco_pkg::CMD_WR_PHASE, 1, 32'h7fff_ffff, 0, 0, 0, 1'b0, 1'b0, 0, 0, 0);
        add_row(mnco_pkg::CMD_WR_AMPL, 1, 32'h0, 32767, 0, 0, 1'b0, 1'b0, 0, 0, 0);
        add_row(mnco_pkg::CMD_RX, 1, 32'h0, 0, 0, 0, 1'b0, 1'b0, 0, 0, 0);
        add_row(mnco_pkg::CMD_TX, 0, 32'h0, 0, 0, 0, 1'b1, 1'b0, 0, 0, 0);
        add_row(mnco_pkg::CMD_READ, 0, 32'h0, 0, 0, 0, 1'b0, 1'b0, 0, 0, 0);
        add_row(mnco_pkg::CMD_WR_STEP, 1, 32'h0010_0000, 0, 0, 0, 1'b0, 1'b0, 0, 0, 0);
        add_row(mnco_pkg::CMD_MOD, 1, 32'h0, 0, 32767, 32767, 1'b1, 1'b0, 0, 0, 0);
        add_row(mnco_pkg::CMD_TX, 9, 32'h0, 0, 0, 0, 1'b0, 1'b0, 0, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            drive_request(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].res);
        end
        // Pause with nothing in flight before the random part.
        s_tvalid <= 1'b0;
        wait_for_drain();
        @(posedge i_clk);

        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < N_RANDOM; n++) begin
            pick      = $urandom_range(0, 99);
            req.cmd   = (pick < 12) ? mnco_pkg::CMD_WR_STEP :
                        (pick < 24) ? mnco_pkg::CMD_WR_PHASE :
                        (pick < 36) ? mnco_pkg::CMD_WR_AMPL :
                        (pick < 48) ? mnco_pkg::CMD_TX :
                        (pick < 66) ? mnco_pkg::CMD_RX :
                        (pick < 84) ? mnco_pkg::CMD_MOD :
                        (pick < 94) ? mnco_pkg::CMD_READ : mnco_pkg::CMD_NOP;
            req.ch    = 4'($urandom_range(0, N_CHAN - 1));
            req.word  = pick_word();
            req.amp   = pick_q15();
            req.si    = pick_q15();
            req.sq    = pick_q15();
            req.last  = 1'($urandom);
            drive_request(req, 1'b0, dummy);
            if (n == 700) begin
                s_tvalid <= 1'b0;
                wait_for_drain();
                @(posedge i_clk);
            end else begin
                burst_left--;
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap > 0) begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                              : $urandom_range(1, 24);
                end
            end
        end
        s_tvalid <= 1'b0;
        wait_for_drain();
        repeat (40) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            error_count++;
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Result side: checks every accepted result and stalls on its own pattern.
    initial begin
        nco_result_t want;
        nco_result_t got;
        int          mode = 0;
        int          mode_cycles = 0;
        int          hold_left = 0;
        bit          hold_done = 1'b0;
        logic [7:0]  ready_mask = 8'b1011_0010;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && m_tready) begin
                got.oi    = o_m_axis_tdata[19:0];
                got.oq    = o_m_axis_tdata[39:20];
                got.step  = o_m_axis_tdata[71:40];
                got.phase = o_m_axis_tdata[103:72];
                got.ampl  = o_m_axis_tdata[119:104];
                got.last  = o_m_axis_tlast;
                if (pending_results.size() == 0) begin
                    $display("%0t: result with no request waiting, got %h", $time,
                             o_m_axis_tdata);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.oi !== want.oi) begin
                        $display("%0t: out_i exp %h got %h", $time, want.oi, got.oi);
                        error_count++;
                    end
                    if (got.oq !== want.oq) begin
                        $display("%0t: out_q exp %h got %h", $time, want.oq, got.oq);
                        error_count++;
                    end
                    if (got.step !== want.step) begin
                        $display("%0t: step exp %h got %h", $time, want.step, got.step);
                        error_count++;
                    end
                    if (got.phase !== want.phase) begin
                        $display("%0t: phase exp %h got %h", $time, want.phase, got.phase);
                        error_count++;
                    end
                    if (got.ampl !== want.ampl) begin
                        $display("%0t: ampl exp %h got %h", $time, want.ampl, got.ampl);
                        error_count++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last exp %b got %b", $time, want.last, got.last);
                        error_count++;
                    end
                end
                results_seen++;
            end
            // One long hold-off so that the block backs up and stalls its input.
            if (!hold_done && results_seen >= 500) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            mode_cycles++;
            if (mode_cycles == 64) begin
                mode_cycles = 0;
                mode = $urandom_range(0, 3);
            end
            ready_mask = {ready_mask[6:0], ready_mask[7]};
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ready_mask[0];
                endcase
            end
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
